// ===== hw/rtl/i2a_pkg.sv =====
`timescale 1ns / 1ps

package i2a_pkg;

  // width of the number that is formatted
  localparam int VALUE_BITS = 64;

  // decimal digits of the largest magnitude, ceil(VALUE_BITS * log10(2))
  localparam int NUM_CELLS = (VALUE_BITS * 30103) / 100000 + 1;
  // hex digits of a value
  localparam int NUM_NIBS  = (VALUE_BITS + 3) / 4;
  // binary shift register, whole nibbles
  localparam int BIN_W     = NUM_NIBS * 4;
  // first cell that takes a hex digit at load
  localparam int HEX_BASE  = NUM_CELLS - NUM_NIBS;
  // conversion cycles, four bits per cycle
  localparam int CONV_STEPS = NUM_NIBS;

  localparam int CNT_W  = $clog2(NUM_CELLS + 1);
  localparam int CONV_W = $clog2(CONV_STEPS + 1);

  // command codes; bit 1 set selects hex
  typedef enum logic [1:0] {
    CMD_SIGNED   = 2'd0,
    CMD_UNSIGNED = 2'd1,
    CMD_HEX      = 2'd2
  } cmd_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // per-cycle command to every cell of the digit chain
  typedef struct packed {
    logic load;
    logic conv;
    logic shift;
  } cell_ctl_t;

  // fixed characters
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;

  // digit to upper-case ascii
  localparam logic [7:0] HEX_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

endpackage

// ===== hw/rtl/integer_to_ascii_formatter_top.sv =====
`timescale 1ns / 1ps

// Integer to ASCII formatter.
// Input channel (in_valid/in_stall) takes a request of in_cmd and in_value:
// signed decimal, unsigned decimal, or upper-case hex with a "0x" prefix.
// Output channel (out_valid/out_stall) returns the text one character per
// transfer, most significant first, with out_last on the final character.
// A request is taken only while the block is idle; one request at a time.
// Decimal: a chain of digit cells does double dabble, four bits per cycle;
// the '-' goes out during the conversion. The chain then walks its 20 cells
// to the top, one per cycle while unstalled, dropping leading zeros.
// Hex: nibbles load straight into the cells; the "0x" prefix goes out, then
// a 16-cell walk hands out the digits.
// Zero formats as a single '0' digit, after the "0x" prefix in hex.
// A stalled output holds its character and the chain waits for it; the next
// request is accepted while the last character may still be held.
// Reset (synchronous, rst_n low) returns to idle and drops any held char.
module integer_to_ascii_formatter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char_out,
  output logic        out_last
);

  localparam int NC = i2a_pkg::NUM_CELLS;
  localparam int VB = i2a_pkg::VALUE_BITS;

  i2a_pkg::state_t state_r, state_nxt;

  logic [i2a_pkg::BIN_W-1:0]  bin_r, bin_nxt;
  logic [i2a_pkg::CONV_W-1:0] conv_cnt_r, conv_cnt_nxt;
  logic [i2a_pkg::CNT_W-1:0]  emit_cnt_r, emit_cnt_nxt;
  logic [1:0]                 pre_cnt_r, pre_cnt_nxt;
  logic                       hex_r, hex_nxt;
  logic                       started_r, started_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;

  i2a_pkg::cell_ctl_t ctl;
  logic       accept;
  logic       slot_free;
  logic       emit_req;
  logic [7:0] emit_char;
  logic       emit_last;

  logic [VB-1:0]             in_v;
  logic                      in_neg;
  logic                      in_hex;
  logic [VB-1:0]             in_mag;
  logic [i2a_pkg::BIN_W-1:0] in_ext;

  logic [3:0] dd_link [NC+1];
  logic [3:0] digits  [NC];
  logic [3:0] top_digit;

  // request decode
  assign in_v   = in_value[VB-1:0];
  // cmd bit 1 selects hex, so the unused code formats as hex too
  assign in_hex = in_cmd[1];
  assign in_neg = (in_cmd == i2a_pkg::CMD_SIGNED) && in_v[VB-1];
  assign in_mag = in_neg ? (~in_v + {{(VB-1){1'b0}}, 1'b1}) : in_v;
  assign in_ext = i2a_pkg::BIN_W'(in_v);

  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign top_digit = digits[NC-1];

  // binary bits feed the bottom cell msb first, bit 0 of the link first
  assign dd_link[0] = {bin_r[i2a_pkg::BIN_W-4], bin_r[i2a_pkg::BIN_W-3],
                       bin_r[i2a_pkg::BIN_W-2], bin_r[i2a_pkg::BIN_W-1]};

  // digit chain, cell 0 least significant
  for (genvar i = 0; i < NC; i++) begin : g_cell
    logic [3:0] load_nib;
    logic [3:0] sh_in;

    if (i >= i2a_pkg::HEX_BASE) begin : g_hex
      assign load_nib = hex_nxt ? in_ext[(i - i2a_pkg::HEX_BASE)*4 +: 4] : 4'd0;
    end else begin : g_dec
      assign load_nib = 4'd0;
    end

    if (i == 0) begin : g_bot
      assign sh_in = 4'd0;
    end else begin : g_mid
      assign sh_in = digits[i-1];
    end

    i2a_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .load_nib (load_nib),
      .dd_in    (dd_link[i]),
      .dd_out   (dd_link[i+1]),
      .sh_in    (sh_in),
      .digit    (digits[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      i2a_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = i2a_pkg::ST_CONV;
        end
      end
      i2a_pkg::ST_CONV: begin
        if (conv_cnt_nxt == '0 && pre_cnt_nxt == 2'd0) begin
          state_nxt = i2a_pkg::ST_EMIT;
        end
      end
      i2a_pkg::ST_EMIT: begin
        if (slot_free && emit_cnt_r == i2a_pkg::CNT_W'(1)) begin
          state_nxt = i2a_pkg::ST_IDLE;
        end
      end
      default: state_nxt = i2a_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_stall     = 1'b1;
    ctl          = '0;
    bin_nxt      = bin_r;
    conv_cnt_nxt = conv_cnt_r;
    emit_cnt_nxt = emit_cnt_r;
    pre_cnt_nxt  = pre_cnt_r;
    hex_nxt      = hex_r;
    started_nxt  = started_r;
    emit_req     = 1'b0;
    emit_char    = i2a_pkg::CH_ZERO;
    emit_last    = 1'b0;
    case (state_r)
      i2a_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        hex_nxt  = in_hex;
        if (accept) begin
          ctl.load     = 1'b1;
          bin_nxt      = i2a_pkg::BIN_W'(in_mag);
          conv_cnt_nxt = in_hex ? '0 : i2a_pkg::CONV_W'(i2a_pkg::CONV_STEPS);
          emit_cnt_nxt = in_hex ? i2a_pkg::CNT_W'(i2a_pkg::NUM_NIBS)
                                : i2a_pkg::CNT_W'(NC);
          pre_cnt_nxt  = in_hex ? 2'd2 : (in_neg ? 2'd1 : 2'd0);
          started_nxt  = 1'b0;
        end
      end
      i2a_pkg::ST_CONV: begin
        // double dabble, four bits a cycle
        if (conv_cnt_r != '0) begin
          ctl.conv     = 1'b1;
          bin_nxt      = bin_r << 4;
          conv_cnt_nxt = conv_cnt_r - i2a_pkg::CONV_W'(1);
        end
        // prefix goes out while the digits form
        if (pre_cnt_r != 2'd0 && slot_free) begin
          emit_req    = 1'b1;
          emit_char   = !hex_r ? i2a_pkg::CH_MINUS
                      : (pre_cnt_r == 2'd2 ? i2a_pkg::CH_ZERO : i2a_pkg::CH_X);
          pre_cnt_nxt = pre_cnt_r - 2'd1;
        end
      end
      i2a_pkg::ST_EMIT: begin
        // walk the chain, skipping leading zeros but keeping the final digit
        if (slot_free) begin
          ctl.shift    = 1'b1;
          emit_cnt_nxt = emit_cnt_r - i2a_pkg::CNT_W'(1);
          emit_last    = (emit_cnt_r == i2a_pkg::CNT_W'(1));
          emit_req     = started_r || (top_digit != 4'd0) || emit_last;
          emit_char    = i2a_pkg::HEX_CHARS[top_digit];
          started_nxt  = started_r || emit_req;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (emit_req) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = emit_char;
      out_last_nxt  = emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i2a_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      conv_cnt_r  <= '0;
      emit_cnt_r  <= '0;
      pre_cnt_r   <= 2'd0;
      hex_r       <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      conv_cnt_r  <= conv_cnt_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      pre_cnt_r   <= pre_cnt_nxt;
      hex_r       <= hex_nxt;
      started_r   <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

  // checks

  // an accepted request starts conversion
  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == i2a_pkg::ST_CONV)
    else $error("accepted request did not start conversion");

  // digit walk starts only once prefix and conversion are done
  a_emit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == i2a_pkg::ST_EMIT |-> (pre_cnt_r == 2'd0 && conv_cnt_r == '0))
    else $error("digit walk began before prefix or conversion finished");

  // the walk always has a digit left to hand out
  a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == i2a_pkg::ST_EMIT |-> emit_cnt_r != '0)
    else $error("digit walk with no digits left");

  // the top cell never carries out of the chain
  a_no_spill: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.conv |-> dd_link[NC] == 4'd0)
    else $error("decimal digit chain overflowed");

endmodule

// ===== hw/rtl/i2a_cell.sv =====
`timescale 1ns / 1ps

module i2a_cell (
  input  logic                clk,
  input  i2a_pkg::cell_ctl_t  ctl,
  input  logic [3:0]          load_nib,
  input  logic [3:0]          dd_in,
  output logic [3:0]          dd_out,
  input  logic [3:0]          sh_in,
  output logic [3:0]          digit
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] dd_val;
  logic [3:0] dd_adj;

  // four shift-and-add-3 steps, one bit in from the lower neighbor per step
  always_comb begin
    dd_val = digit_r;
    dd_adj = digit_r;
    dd_out = 4'd0;
    for (int k = 0; k < 4; k++) begin
      dd_adj    = (dd_val >= 4'd5) ? dd_val + 4'd3 : dd_val;
      dd_out[k] = dd_adj[3];
      dd_val    = {dd_adj[2:0], dd_in[k]};
    end
  end

  // load, convert or move one place toward the top of the chain
  always_comb begin
    digit_nxt = digit_r;
    if (ctl.load) begin
      digit_nxt = load_nib;
    end else if (ctl.conv) begin
      digit_nxt = dd_val;
    end else if (ctl.shift) begin
      digit_nxt = sh_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule

// ===== tb/integer_to_ascii_formatter_top_tb.sv =====
`timescale 1ns / 1ps

module integer_to_ascii_formatter_top_tb;

  // spare command code, decoded as hex by the block
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 236;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 60;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [63:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_char_out;
  logic        out_last;

  // shared pacing controls
  bit no_idle;
  bit hold_off;
  int input_held_cycles;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  // expected text of every accepted request, in order
  class ascii_scoreboard;
    text_char_t pending_text[$];
    int mismatches;
    int chars_checked;
    int signed_reqs;
    int unsigned_reqs;
    int hex_reqs;

    function void note_request(input logic [1:0] cmd, input logic [63:0] value);
      logic [63:0] mask;
      logic [63:0] mag;
      logic [7:0]  digits[$];
      bit          neg;
      mask = {64{1'b1}} >> (64 - i2a_pkg::VALUE_BITS);
      mag  = value & mask;
      neg  = 1'b0;
      if (cmd[1]) begin
        // hex, prefix first, then nibbles from the top
        hex_reqs++;
        do begin
          digits.push_front(i2a_pkg::HEX_CHARS[mag[3:0]]);
          mag = mag >> 4;
        end while (mag != 0);
        pending_text.push_back('{ch: i2a_pkg::CH_ZERO, last: 1'b0});
        pending_text.push_back('{ch: i2a_pkg::CH_X, last: 1'b0});
      end else begin
        if (cmd == i2a_pkg::CMD_SIGNED) signed_reqs++;
        else unsigned_reqs++;
        // magnitude of a negative number in unsigned arithmetic
        if (cmd == i2a_pkg::CMD_SIGNED && mag[i2a_pkg::VALUE_BITS-1]) begin
          neg = 1'b1;
          mag = 64'd0 - (mag | ~mask);
        end
        do begin
          digits.push_front(i2a_pkg::CH_ZERO + 8'(mag % 64'd10));
          mag = mag / 64'd10;
        end while (mag != 0);
        if (neg) pending_text.push_back('{ch: i2a_pkg::CH_MINUS, last: 1'b0});
      end
      foreach (digits[i]) begin
        pending_text.push_back('{ch: digits[i], last: (i == digits.size() - 1)});
      end
    endfunction

    function void check_char(input logic [7:0] ch, input logic last);
      text_char_t want;
      if (pending_text.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected char: expected none, actual char %h last %b",
                 $time, ch, last);
        return;
      end
      want = pending_text.pop_front();
      chars_checked++;
      if (ch !== want.ch) begin
        mismatches++;
        $display("%0t: char_out mismatch: expected %h, actual %h", $time, want.ch, ch);
      end
      if (last !== want.last) begin
        mismatches++;
        $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, last);
      end
    endfunction
  endclass

  ascii_scoreboard sb;

  integer_to_ascii_formatter_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_out (out_char_out),
    .out_last     (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one request and wait until the block takes it
  task automatic send_request(input logic [1:0] cmd, input logic [63:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_value <= value;
    @(posedge clk);
    while (in_stall) begin
      input_held_cycles++;
      @(posedge clk);
    end
    sb.note_request(cmd, value);
    @(negedge clk);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int wait_cycles;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
      wait_cycles = no_idle ? 0 : $urandom_range(0, 15);
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      sb.check_char(out_char_out, out_last);
    end
  end

  // watchdog on cycles with no transfer on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [1:0]  cmd;
    logic [63:0] value;
    logic [63:0] raw;
    int          sel;
    sb = new();
    no_idle  = 1'b0;
    hold_off = 1'b0;
    input_held_cycles = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_cmd   <= i2a_pkg::CMD_SIGNED;
    in_value <= 64'd0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, every mode, zero, most negative, spare code
    send_request(i2a_pkg::CMD_SIGNED,   64'd0);
    send_request(i2a_pkg::CMD_SIGNED,   64'd1);
    send_request(i2a_pkg::CMD_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF);
    send_request(i2a_pkg::CMD_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF);
    send_request(i2a_pkg::CMD_SIGNED,   64'h8000_0000_0000_0000);
    send_request(i2a_pkg::CMD_SIGNED,   64'hFFFF_FFFF_FFFF_FFF6);
    send_request(i2a_pkg::CMD_SIGNED,   64'd9);
    send_request(i2a_pkg::CMD_SIGNED,   64'd10);
    send_request(i2a_pkg::CMD_UNSIGNED, 64'd0);
    send_request(i2a_pkg::CMD_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(i2a_pkg::CMD_UNSIGNED, 64'h8000_0000_0000_0000);
    send_request(i2a_pkg::CMD_UNSIGNED, 64'd9999999999999999999);
    send_request(i2a_pkg::CMD_UNSIGNED, 64'd10000000000000000000);
    send_request(i2a_pkg::CMD_UNSIGNED, 64'd12345);
    send_request(i2a_pkg::CMD_HEX,      64'd0);
    send_request(i2a_pkg::CMD_HEX,      64'hFFFF_FFFF_FFFF_FFFF);
    send_request(i2a_pkg::CMD_HEX,      64'hF);
    send_request(i2a_pkg::CMD_HEX,      64'h10);
    send_request(i2a_pkg::CMD_HEX,      64'h0123_4567_89AB_CDEF);
    send_request(i2a_pkg::CMD_HEX,      64'h8000_0000_0000_0000);
    send_request(CMD_SPARE,             64'd0);
    send_request(CMD_SPARE,             64'hDEAD_BEEF_CAFE_F00D);
    send_request(CMD_SPARE,             64'hFFFF_FFFF_FFFF_FFFF);
    send_request(i2a_pkg::CMD_SIGNED,   64'h5555_5555_5555_5555);

    // random: stretches without idling, one long receiver hold-off
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 100) hold_off = 1'b1;
      no_idle = ((k / 30) % 4 == 3) || (k >= 100 && k < 110);
      sel = $urandom_range(0, 9);
      if (sel < 3) cmd = i2a_pkg::CMD_SIGNED;
      else if (sel < 6) cmd = i2a_pkg::CMD_UNSIGNED;
      else if (sel < 9) cmd = i2a_pkg::CMD_HEX;
      else cmd = CMD_SPARE;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: value = raw;
        1: value = raw >> $urandom_range(0, 63);
        2: value = ~(raw >> $urandom_range(1, 63));
        default: begin
          // around a power of ten
          value = 64'd1;
          repeat ($urandom_range(0, 19)) value = value * 64'd10;
          value = value - 64'd1 + 64'($urandom_range(0, 2));
        end
      endcase
      send_request(cmd, value);
    end
    no_idle  = 1'b0;
    in_valid <= 1'b0;

    // drain
    while (sb.pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d signed, %0d unsigned and %0d hex requests, %0d chars checked",
             sb.signed_reqs, sb.unsigned_reqs, sb.hex_reqs, sb.chars_checked);
    $display("input held off for %0d cycles, %0d mismatches",
             input_held_cycles, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
